// File: rtl/core/ffem_pkg.sv
package ffem_pkg;

	// Fixed field widths of the channels
	localparam int ACT_W = 2;
	localparam int ID_W  = 16;
	localparam int AMT_W = 32;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REFER  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;          // latch request, clear walk state
		logic ptr_zero;      // walk pointer to first entry
		logic ptr_top;       // walk pointer to entry count (downward walk)
		logic rd_up;         // read at pointer, advance
		logic rd_dn;         // read below pointer, step back
		logic plan_take;     // consume a whole free extent
		logic plan_split;    // record split point and remainder
		logic stop_here;     // claim limit at current entry
		logic stop_next;     // claim limit after current entry
		logic stop_end;      // claim limit at entry count
		logic wr_claim;      // mark current entry owned
		logic wr_shift;      // move current entry up by one
		logic wr_split_own;  // owned front part at split point
		logic wr_split_rest; // free remainder after split point
		logic wr_append;     // owned extent at end of table
		logic wr_free;       // mark current entry free
		logic cnt_inc;       // one more entry in table
		logic acc;           // add current length to running end
		logic set_hit;       // record owner of current entry
		logic set_ovf;       // record dropped write
		logic out_load;      // move result into output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic amt_zero;
		logic v_s1;
		logic free_s1;
		logic fits;
		logic exact;
		logic owner_match;
		logic ref_hit;
		logic below_count;
		logic below_stop;
		logic above_split;
		logic has_split;
		logic left_nz;
		logic full;
	} stat_t;

endpackage

// File: rtl/core/ffem_req_if.sv
interface ffem_req_if;
	logic                         valid;
	logic                         ready;
	logic [ffem_pkg::ACT_W-1:0]   action;
	logic [ffem_pkg::ID_W-1:0]    file_id;
	logic [ffem_pkg::AMT_W-1:0]   amount;

	modport source (output valid, action, file_id, amount, input ready);
	modport sink (input valid, action, file_id, amount, output ready);
endinterface

// File: rtl/core/ffem_rsp_if.sv
interface ffem_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         owner_found;
	logic [ffem_pkg::ID_W-1:0]    owner_id;
	logic                         overflow;

	modport source (output valid, owner_found, owner_id, overflow, input ready);
	modport sink (input valid, owner_found, owner_id, overflow, output ready);
endinterface

// File: rtl/core/ffem_datapath.sv
module ffem_datapath #(
	parameter int MAX_EXTENTS = 64,
	parameter int ID_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffem_pkg::cmd_t                cmd,
	output ffem_pkg::stat_t               stat,
	input  logic [ffem_pkg::ACT_W-1:0]    in_action,
	input  logic [ffem_pkg::ID_W-1:0]     in_file_id,
	input  logic [ffem_pkg::AMT_W-1:0]    in_amount,
	output logic                          out_found,
	output logic [ffem_pkg::ID_W-1:0]     out_owner,
	output logic                          out_overflow
);

	localparam int IDXW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW   = $clog2(MAX_EXTENTS + 1);
	localparam int OW   = ffem_pkg::ID_W;
	localparam int IDW  = (ID_BITS < OW) ? ID_BITS : OW;
	localparam int LW   = ffem_pkg::AMT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

	typedef struct packed {
		logic [IDW-1:0] owner;
		logic           free;
		logic [LW-1:0]  len;
	} ent_t;

	ent_t mem [MAX_EXTENTS];

	logic [ffem_pkg::ACT_W-1:0] op_q;
	logic [IDW-1:0]  id_q;
	logic [LW-1:0]   amt_q;
	logic [LW-1:0]   left_q;
	logic [LW-1:0]   rest_q;
	logic [IDXW-1:0] split_q;
	logic            has_split_q;
	logic [CW-1:0]   stop_q;
	logic [LW:0]     end_q;
	logic [CW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            v_s1;
	logic [IDXW-1:0] idx_s1;
	ent_t            ent_s1;
	logic            res_found_q;
	logic [OW-1:0]   res_owner_q;
	logic            res_ovf_q;
	logic            out_found_q;
	logic [OW-1:0]   out_owner_q;
	logic            out_ovf_q;

	logic            rd;
	logic [IDXW-1:0] rd_addr;
	logic            we;
	logic [IDXW-1:0] wa;
	ent_t            wd;
	logic [LW:0]     end_next;

	// Read address: upward walks read at the pointer, downward below it
	assign rd      = cmd.rd_up | cmd.rd_dn;
	assign rd_addr = cmd.rd_dn ? IDXW'(rd_ptr_q - CW'(1)) : IDXW'(rd_ptr_q);
	assign end_next = end_q + {1'b0, ent_s1.len};

	// Status toward the controller
	always_comb begin
		stat.action      = op_q;
		stat.amt_zero    = (amt_q == '0);
		stat.v_s1        = v_s1;
		stat.free_s1     = ent_s1.free;
		stat.fits        = (left_q >= ent_s1.len);
		stat.exact       = (left_q == ent_s1.len);
		stat.owner_match = (ent_s1.owner == id_q);
		stat.ref_hit     = (end_next > {1'b0, amt_q});
		stat.below_count = (rd_ptr_q < count_q);
		stat.below_stop  = (rd_ptr_q < stop_q);
		stat.above_split = (rd_ptr_q > CW'(split_q));
		stat.has_split   = has_split_q;
		stat.left_nz     = (left_q != '0);
		stat.full        = (count_q == MAX_CNT);
	end

	// Select the single table write of this cycle
	always_comb begin
		we = 1'b1;
		wa = idx_s1;
		wd = ent_s1;
		if (cmd.wr_claim) begin
			wd.owner = id_q;
			wd.free  = 1'b0;
		end else if (cmd.wr_shift) begin
			wa = IDXW'(idx_s1 + 1'b1);
		end else if (cmd.wr_split_own) begin
			wa = split_q;
			wd = '{owner: id_q, free: 1'b0, len: left_q};
		end else if (cmd.wr_split_rest) begin
			wa = IDXW'(split_q + 1'b1);
			wd = '{owner: '0, free: 1'b1, len: rest_q};
		end else if (cmd.wr_append) begin
			wa = IDXW'(count_q);
			wd = '{owner: id_q, free: 1'b0, len: left_q};
		end else if (cmd.wr_free) begin
			wd.owner = '0;
			wd.free  = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	// Extent table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd) begin
			ent_s1 <= mem[rd_addr];
			idx_s1 <= rd_addr;
		end
	end

	// Control state: entry count, read stage valid, walk pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			v_s1     <= 1'b0;
			rd_ptr_q <= '0;
		end else begin
			v_s1 <= rd;
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.load || cmd.ptr_zero) begin
				rd_ptr_q <= '0;
			end else if (cmd.ptr_top) begin
				rd_ptr_q <= count_q;
			end else if (cmd.rd_up) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end else if (cmd.rd_dn) begin
				rd_ptr_q <= rd_ptr_q - CW'(1);
			end
		end
	end

	// Request, walk bookkeeping and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= in_action;
			id_q        <= in_file_id[IDW-1:0];
			amt_q       <= in_amount;
			left_q      <= in_amount;
			has_split_q <= 1'b0;
			end_q       <= '0;
			res_found_q <= 1'b0;
			res_owner_q <= '0;
			res_ovf_q   <= 1'b0;
		end
		if (cmd.plan_take) begin
			left_q <= left_q - ent_s1.len;
		end
		if (cmd.plan_split) begin
			split_q     <= idx_s1;
			rest_q      <= ent_s1.len - left_q;
			has_split_q <= 1'b1;
		end
		if (cmd.stop_here) begin
			stop_q <= CW'(idx_s1);
		end else if (cmd.stop_next) begin
			stop_q <= CW'(idx_s1) + CW'(1);
		end else if (cmd.stop_end) begin
			stop_q <= count_q;
		end
		if (cmd.acc) begin
			end_q <= end_next;
		end
		if (cmd.set_hit) begin
			res_found_q <= ~ent_s1.free;
			res_owner_q <= ent_s1.free ? '0 : OW'(ent_s1.owner);
		end
		if (cmd.set_ovf) begin
			res_ovf_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_owner_q <= res_owner_q;
			out_ovf_q   <= res_ovf_q;
		end
	end

	assign out_found    = out_found_q;
	assign out_owner    = out_owner_q;
	assign out_overflow = out_ovf_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("extent count beyond table size");

	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q != MAX_CNT)
		else $error("table grown while full");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_claim, cmd.wr_shift, cmd.wr_split_own, cmd.wr_split_rest,
			cmd.wr_append, cmd.wr_free}))
		else $error("more than one table write in a cycle");

	a_dn_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_dn |-> rd_ptr_q != '0)
		else $error("downward walk below first entry");

endmodule

// File: rtl/core/ffem_ctrl.sv
module ffem_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ffem_pkg::stat_t  stat,
	output ffem_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		IDLE,
		DISPATCH,
		PLAN,
		CHECK,
		CLAIM,
		SHIFT,
		SPLIT_OWN,
		SPLIT_REST,
		APPEND,
		DEL,
		REF,
		DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == IDLE);
		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = DISPATCH;
				end
			end
			DISPATCH: begin
				case (stat.action)
					ffem_pkg::ACT_WRITE:  state_d = stat.amt_zero ? DONE : PLAN;
					ffem_pkg::ACT_DELETE: state_d = DEL;
					ffem_pkg::ACT_REFER:  state_d = REF;
					default:              state_d = DONE;
				endcase
			end
			// Walk free extents to find where the request ends
			PLAN: begin
				cmd.rd_up = stat.below_count;
				if (stat.v_s1 && stat.free_s1) begin
					if (stat.fits) begin
						cmd.plan_take = 1'b1;
						if (stat.exact) begin
							cmd.stop_next = 1'b1;
							state_d       = CHECK;
						end
					end else begin
						cmd.plan_split = 1'b1;
						cmd.stop_here  = 1'b1;
						state_d        = CHECK;
					end
				end else if (!stat.v_s1 && !stat.below_count) begin
					cmd.stop_end = 1'b1;
					state_d      = CHECK;
				end
			end
			// Drop the write when it needs a new entry and the table is full
			CHECK: begin
				if ((stat.has_split || stat.left_nz) && stat.full) begin
					cmd.set_ovf = 1'b1;
					state_d     = DONE;
				end else begin
					cmd.ptr_zero = 1'b1;
					state_d      = CLAIM;
				end
			end
			// Claim whole free extents below the limit
			CLAIM: begin
				cmd.rd_up = stat.below_stop;
				if (stat.v_s1 && stat.free_s1) begin
					cmd.wr_claim = 1'b1;
				end
				if (!stat.v_s1 && !stat.below_stop) begin
					if (stat.has_split) begin
						cmd.ptr_top = 1'b1;
						state_d     = SHIFT;
					end else if (stat.left_nz) begin
						state_d = APPEND;
					end else begin
						state_d = DONE;
					end
				end
			end
			// Move entries from the top down to open a slot after the split
			SHIFT: begin
				cmd.rd_dn = stat.above_split;
				if (stat.v_s1) begin
					cmd.wr_shift = 1'b1;
				end else if (!stat.above_split) begin
					state_d = SPLIT_OWN;
				end
			end
			SPLIT_OWN: begin
				cmd.wr_split_own = 1'b1;
				state_d          = SPLIT_REST;
			end
			SPLIT_REST: begin
				cmd.wr_split_rest = 1'b1;
				cmd.cnt_inc       = 1'b1;
				state_d           = DONE;
			end
			APPEND: begin
				cmd.wr_append = 1'b1;
				cmd.cnt_inc   = 1'b1;
				state_d       = DONE;
			end
			// Free every extent of the id
			DEL: begin
				cmd.rd_up = stat.below_count;
				if (stat.v_s1 && !stat.free_s1 && stat.owner_match) begin
					cmd.wr_free = 1'b1;
				end
				if (!stat.v_s1 && !stat.below_count) begin
					state_d = DONE;
				end
			end
			// Add lengths until the sector index is passed
			REF: begin
				cmd.rd_up = stat.below_count;
				if (stat.v_s1) begin
					cmd.acc = 1'b1;
					if (stat.ref_hit) begin
						cmd.set_hit = 1'b1;
						state_d     = DONE;
					end
				end else if (!stat.below_count) begin
					state_d = DONE;
				end
			end
			// Hold the result until the output register is free
			DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: state_d = IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == DISPATCH)
		else $error("accepted request not dispatched");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.out_load)
		else $error("stalled result overwritten");

	a_grow_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> state_q == DONE)
		else $error("table grown outside write completion");

endmodule

// File: rtl/core/first_fit_extent_map.sv
// First-fit extent map.
// req (sink): action, file_id, amount. A write (action 0) claims amount sectors
// from free extents in table order, splitting the last one and appending what
// is left; delete (1) frees every extent of file_id; reference (2) reports the
// owner of sector index amount. Action 3 does nothing.
// rsp (source): one result per request: owner_found, owner_id, overflow.
// req.ready is high only while no request is in work; a result sits in an
// output register, so the next request is taken while it waits.
// Reference and delete walk the table at most once; a write walks it once to
// plan, once to claim and, for a split, once more downward from the top to the
// split point to open a slot; a dropped write stops after the plan walk.
// Each walk reads one extent table entry per cycle. A new request is taken
// only once the previous one is finished.
// Reset empties the table; no clearing pass is needed.
// When rsp.ready stays low the finished result holds and the block stalls
// before delivering the next one.
module first_fit_extent_map #(
	parameter int MAX_EXTENTS = 64,
	parameter int ID_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ffem_req_if.sink    req,
	ffem_rsp_if.source  rsp
);

	ffem_pkg::cmd_t  cmd;
	ffem_pkg::stat_t stat;

	ffem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffem_datapath #(
		.MAX_EXTENTS (MAX_EXTENTS),
		.ID_BITS     (ID_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_action    (req.action),
		.in_file_id   (req.file_id),
		.in_amount    (req.amount),
		.out_found    (rsp.owner_found),
		.out_owner    (rsp.owner_id),
		.out_overflow (rsp.overflow)
	);

endmodule

// File: dv/tb_first_fit_extent_map.sv
module tb_first_fit_extent_map;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 4;
	localparam int TABLE_DEPTH   = 64;
	localparam int ID_POOL_SIZE  = 12;
	localparam int NUM_DIRECTED  = 25;
	localparam int NUM_RANDOM    = 1080;
	localparam int FILL_HORIZON  = 700;
	localparam int DRAIN_EVERY   = 270;
	localparam int TAIL_CYCLES   = 3 * TABLE_DEPTH + 16;
	localparam int STALL_LIMIT   = 5000;

	typedef struct packed {
		logic [ffem_pkg::ACT_W-1:0] action;
		logic [ffem_pkg::ID_W-1:0]  file_id;
		logic [ffem_pkg::AMT_W-1:0] amount;
	} map_req_t;

	typedef struct packed {
		logic                      found;
		logic [ffem_pkg::ID_W-1:0] owner;
		logic                      ovf;
	} owner_rsp_t;

	// fixed = 1: the typed result is the expectation; else the predictor decides
	typedef struct packed {
		logic [ffem_pkg::ACT_W-1:0] action;
		logic [ffem_pkg::ID_W-1:0]  file_id;
		logic [ffem_pkg::AMT_W-1:0] amount;
		logic                       fixed;
		logic                       found;
		logic [ffem_pkg::ID_W-1:0]  owner;
		logic                       ovf;
	} directed_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ffem_req_if req_ch ();
	ffem_rsp_if rsp_ch ();

	first_fit_extent_map #(
		.MAX_EXTENTS(TABLE_DEPTH),
		.ID_BITS(ffem_pkg::ID_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow extent table
	logic [ffem_pkg::ID_W-1:0]  ext_owner [TABLE_DEPTH];
	bit                         ext_free  [TABLE_DEPTH];
	logic [ffem_pkg::AMT_W-1:0] ext_len   [TABLE_DEPTH];
	int                         ext_cnt = 0;

	owner_rsp_t                pending_rsp [$];
	logic [ffem_pkg::ID_W-1:0] id_pool [ID_POOL_SIZE];
	int                        burst_left = 0;
	int                        n_errors = 0;
	int                        quiet_cycles = 0;

	int n_writes = 0, n_deletes = 0, n_refs = 0, n_nops = 0;
	int n_ovf = 0, n_split = 0, n_append = 0, n_hits = 0, peak_cnt = 0;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_DELETE, 16'h0042, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h1234, 32'h0000_0000, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_NOP,    16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h0001, 32'd10,        1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'hFFFF, 32'd5,         1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h0003, 32'd7,         1'b1, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'd0,         1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'd10,        1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'd21,        1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'd22,        1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_DELETE, 16'hFFFF, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'd12,        1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h0004, 32'd5,         1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_DELETE, 16'h0004, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h0005, 32'd3,         1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'd13,        1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h0006, 32'd4,         1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_DELETE, 16'h0000, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h0000, 32'h8000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_WRITE,  16'hAAAA, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
		'{ffem_pkg::ACT_REFER,  16'h5555, 32'h4000_0000, 1'b0, 1'b0, 16'h0000, 1'b0}
	};

	// Claim free extents first-fit; split the last one or append the rest.
	// Return 1 when the write is dropped for lack of table room.
	function automatic logic claim_sectors(input logic [ffem_pkg::ID_W-1:0] id,
		input logic [ffem_pkg::AMT_W-1:0] want);
		logic [ffem_pkg::AMT_W-1:0] left;
		int                         split_at;
		int                         i;
		int                         j;

		left = want;
		split_at = -1;
		if (want == '0)
			return 1'b0;
		// plan first so a dropped write leaves the table alone
		for (i = 0; i < ext_cnt && left != '0; i++) begin
			if (ext_free[i]) begin
				if (left >= ext_len[i]) begin
					left -= ext_len[i];
				end else begin
					split_at = i;
					break;
				end
			end
		end
		if ((split_at >= 0 || left != '0) && ext_cnt >= TABLE_DEPTH)
			return 1'b1;
		left = want;
		for (i = 0; i < ext_cnt && left != '0; i++) begin
			if (!ext_free[i])
				continue;
			if (i == split_at) begin
				// open a slot above the split point for the free remainder
				for (j = ext_cnt; j > i; j--) begin
					ext_owner[j] = ext_owner[j - 1];
					ext_free[j]  = ext_free[j - 1];
					ext_len[j]   = ext_len[j - 1];
				end
				ext_owner[i + 1] = '0;
				ext_free[i + 1]  = 1'b1;
				ext_len[i + 1]   = ext_len[i] - left;
				ext_owner[i]     = id;
				ext_free[i]      = 1'b0;
				ext_len[i]       = left;
				ext_cnt++;
				n_split++;
				return 1'b0;
			end
			ext_owner[i] = id;
			ext_free[i]  = 1'b0;
			left -= ext_len[i];
		end
		if (left != '0) begin
			ext_owner[ext_cnt] = id;
			ext_free[ext_cnt]  = 1'b0;
			ext_len[ext_cnt]   = left;
			ext_cnt++;
			n_append++;
		end
		return 1'b0;
	endfunction

	// Walk running extent ends to find the owner of a sector
	function automatic owner_rsp_t find_owner(input logic [ffem_pkg::AMT_W-1:0] sector);
		owner_rsp_t  r;
		logic [63:0] run_end;
		int          i;

		r = '0;
		run_end = '0;
		for (i = 0; i < ext_cnt; i++) begin
			run_end += 64'(ext_len[i]);
			if (run_end > 64'(sector)) begin
				if (!ext_free[i]) begin
					r.found = 1'b1;
					r.owner = ext_owner[i];
				end
				return r;
			end
		end
		return r;
	endfunction

	// Update the shadow table for one request and return its result
	function automatic owner_rsp_t apply_request(input map_req_t rq);
		owner_rsp_t r;
		int         i;

		r = '0;
		case (rq.action)
			ffem_pkg::ACT_WRITE: begin
				r.ovf = claim_sectors(rq.file_id, rq.amount);
				n_writes++;
				if (r.ovf)
					n_ovf++;
			end
			ffem_pkg::ACT_DELETE: begin
				for (i = 0; i < ext_cnt; i++) begin
					if (!ext_free[i] && ext_owner[i] == rq.file_id) begin
						ext_free[i]  = 1'b1;
						ext_owner[i] = '0;
					end
				end
				n_deletes++;
			end
			ffem_pkg::ACT_REFER: begin
				r = find_owner(rq.amount);
				n_refs++;
				if (r.found)
					n_hits++;
			end
			default: n_nops++;
		endcase
		if (ext_cnt > peak_cnt)
			peak_cnt = ext_cnt;
		return r;
	endfunction

	// Total length of the first k free extents in table order
	function automatic logic [63:0] free_span(input int k);
		logic [63:0] sum;
		int          seen;
		int          i;

		sum = '0;
		seen = 0;
		for (i = 0; i < ext_cnt && seen < k; i++) begin
			if (ext_free[i]) begin
				sum += 64'(ext_len[i]);
				seen++;
			end
		end
		return sum;
	endfunction

	// Random request shaped by the shadow table: the table grows slowly so that
	// splits, exact fits and overflow all get long stretches
	function automatic map_req_t random_req(input int idx);
		map_req_t    rq;
		logic [63:0] total;
		logic [63:0] lo;
		logic [63:0] seg;
		logic [63:0] sector;
		int          n_free;
		int          n_owned;
		int          pick;
		int          k;
		int          sel;
		int          seen;
		int          i;
		bit          can_grow;

		rq.action  = ffem_pkg::ACT_NOP;
		rq.file_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
		rq.amount  = $urandom;
		total   = '0;
		n_free  = 0;
		n_owned = 0;
		for (i = 0; i < ext_cnt; i++) begin
			total += 64'(ext_len[i]);
			if (ext_free[i])
				n_free++;
			else
				n_owned++;
		end
		can_grow = (ext_cnt < 4 + idx * TABLE_DEPTH / FILL_HORIZON) ||
			(ext_cnt >= TABLE_DEPTH && $urandom_range(0, 2) == 0);
		pick = $urandom_range(0, 99);
		// nothing free to fill exactly: free something instead
		if (pick < 42 && !can_grow && n_free == 0)
			pick = 50;

		if (pick < 42) begin
			rq.action = ffem_pkg::ACT_WRITE;
			k = $urandom_range(0, 39);
			if (!can_grow) begin
				lo = free_span($urandom_range(1, n_free < 4 ? n_free : 4));
				rq.amount = (lo > 64'hFFFF_FFFF) ? '0 : lo[31:0];
			end else if (k == 0) begin
				rq.amount = $urandom;
			end else if (k == 1) begin
				rq.amount = '0;
			end else if (k < 12 && n_free > 0) begin
				// end the request inside a free extent
				sel = $urandom_range(1, n_free);
				lo  = free_span(sel - 1);
				seg = free_span(sel) - lo;
				lo += (seg > 1) ? 64'($urandom_range(1, 32'(seg) - 1)) : 64'd1;
				rq.amount = (lo > 64'hFFFF_FFFF) ? 32'($urandom_range(1, 48)) : lo[31:0];
			end else begin
				rq.amount = $urandom_range(1, 48);
			end
		end else if (pick < 67) begin
			rq.action = ffem_pkg::ACT_DELETE;
			if (n_owned > 0 && $urandom_range(0, 3) != 0) begin
				sel = $urandom_range(0, n_owned - 1);
				seen = 0;
				for (i = 0; i < ext_cnt; i++) begin
					if (!ext_free[i]) begin
						if (seen == sel)
							rq.file_id = ext_owner[i];
						seen++;
					end
				end
			end else if ($urandom_range(0, 1) == 0) begin
				rq.file_id = 16'($urandom);
			end
		end else if (pick < 96) begin
			rq.action = ffem_pkg::ACT_REFER;
			k = $urandom_range(0, 19);
			if (ext_cnt > 0 && k < 14) begin
				// aim at a chosen extent: its first, its last or any sector
				sel = $urandom_range(0, ext_cnt - 1);
				sector = '0;
				for (i = 0; i < sel; i++)
					sector += 64'(ext_len[i]);
				if (k < 3)
					sector += 0;
				else if (k < 6)
					sector += 64'(ext_len[sel]) - 1;
				else
					sector += 64'($urandom_range(0, ext_len[sel] - 1));
				rq.amount = (sector > 64'hFFFF_FFFF) ? $urandom : sector[31:0];
			end else if (k < 16) begin
				rq.amount = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
			end else if (k < 18) begin
				rq.amount = 32'hFFFF_FFFF;
			end
		end else begin
			rq.file_id = 16'($urandom);
		end
		return rq;
	endfunction

	// Drive one request, hold it until the transfer, then record its result
	task automatic issue(input map_req_t rq, input bit use_typed, input owner_rsp_t typed_rsp);
		owner_rsp_t predicted;

		req_ch.valid   <= 1'b1;
		req_ch.action  <= rq.action;
		req_ch.file_id <= rq.file_id;
		req_ch.amount  <= rq.amount;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_request(rq);
		pending_rsp.insert(pending_rsp.size(), use_typed ? typed_rsp : predicted);
	endtask

	// Insert a random gap at the end of each burst
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
		end
	endtask

	// Hold off the sender until every result is back
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	// Compare one result transfer against the oldest expectation
	task automatic check_rsp();
		owner_rsp_t want;

		if (pending_rsp.size() == 0) begin
			$error("unexpected result: owner_found %0d owner_id 0x%04h overflow %0d",
				rsp_ch.owner_found, rsp_ch.owner_id, rsp_ch.overflow);
			n_errors++;
			return;
		end
		want = pending_rsp.pop_front();
		if (rsp_ch.owner_found !== want.found) begin
			$error("owner_found: expected %0d, got %0d", want.found, rsp_ch.owner_found);
			n_errors++;
		end
		if (rsp_ch.owner_id !== want.owner) begin
			$error("owner_id: expected 0x%04h, got 0x%04h", want.owner, rsp_ch.owner_id);
			n_errors++;
		end
		if (rsp_ch.overflow !== want.ovf) begin
			$error("overflow: expected %0d, got %0d", want.ovf, rsp_ch.overflow);
			n_errors++;
		end
	endtask

	// Receiver: check each transfer, stall on a mode that changes now and then
	initial begin : rsp_side
		int rx_phase;
		int rx_mode;

		rx_phase = 0;
		rx_mode  = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				check_rsp();
			rx_phase++;
			if (rx_phase % 200 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2: rsp_ch.ready <= ($urandom_range(0, 9) < 4);
				default: rsp_ch.ready <= ((rx_phase % 7) < 4);
			endcase
		end
	end

	// Abort when no transfer happens on either channel for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		map_req_t   rq;
		owner_rsp_t typed;
		int         i;

		req_ch.valid   <= 1'b0;
		req_ch.action  <= ffem_pkg::ACT_NOP;
		req_ch.file_id <= '0;
		req_ch.amount  <= '0;
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		for (i = 2; i < ID_POOL_SIZE; i++)
			id_pool[i] = 16'($urandom);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: empty table, zero-length, extremes, split, free remainder
		for (i = 0; i < NUM_DIRECTED; i++) begin
			rq.action  = directed_rows[i].action;
			rq.file_id = directed_rows[i].file_id;
			rq.amount  = directed_rows[i].amount;
			typed.found = directed_rows[i].found;
			typed.owner = directed_rows[i].owner;
			typed.ovf   = directed_rows[i].ovf;
			issue(rq, directed_rows[i].fixed, typed);
			pace();
		end
		hold_until_drained();

		// random traffic, draining now and then
		for (i = 0; i < NUM_RANDOM; i++) begin
			issue(random_req(i), 1'b0, '0);
			if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
				hold_until_drained();
			else
				pace();
		end

		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d writes (%0d splits, %0d appends, %0d dropped), %0d deletes, %0d no-ops",
			n_writes, n_split, n_append, n_ovf, n_deletes, n_nops);
		$display("and %0d lookups (%0d owned hits); table reached %0d of %0d extents",
			n_refs, n_hits, peak_cnt, TABLE_DEPTH);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
